[rtl/mbp_pkg.sv]
// ----------------------------------------------------------------------------
// mbp_pkg
// shared types and constants for the mips branch predecoder
// ----------------------------------------------------------------------------
package mbp_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // register byte addresses
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_LITTLE_ENDIAN = 3'd0;

   typedef enum logic [3:0] {
      CLASS_OTHER    = 4'd0,
      CLASS_LOAD     = 4'd1,
      CLASS_STORE    = 4'd2,
      CLASS_COND     = 4'd3,
      CLASS_UNC_DIR  = 4'd4,
      CLASS_UNC_IND  = 4'd5,
      CLASS_CALL     = 4'd6,
      CLASS_CALL_IND = 4'd7,
      CLASS_RETURN   = 4'd8,
      CLASS_SYSTRAP  = 4'd9
   } insn_class_type;

   typedef struct packed {
      logic [31:0] instruction_bytes;
      logic [63:0] program_counter;
   } req_word_type;

   typedef struct packed {
      insn_class_type insn_class;
      logic [63:0]    target_address;
      logic           target_valid;
      logic           delay_slots;
   } rsp_word_type;

endpackage

[rtl/mips_branch_predecoder_top.sv]
// ----------------------------------------------------------------------------
// mips_branch_predecoder_top
// predecodes one mips instruction word per cycle into class, target and
// delay-slot count
// ----------------------------------------------------------------------------
//
//   channel   ports   direction   word
//   request   req_*   in          instruction_bytes, program_counter
//   response  rsp_*   out         insn_class, target_address, target_valid,
//                                 delay_slots
//   csr       csr_*   in/out      little_endian at byte address 0
//
// one word per cycle sustained while rsp is not stalled; a taken word goes
// through the input register, then decode into the response register
// the input register also loads whenever it is empty; both registers move
// together when the response register is free or being drained, so a stall
// on rsp backs up through req_ready once both stages hold a word
// reset is synchronous; it empties both stages and selects big-endian
// ----------------------------------------------------------------------------
module mips_branch_predecoder_top
   import mbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,

   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,

   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // configuration register
   logic little_endian_ff;
   logic little_endian_in;
   logic csr_write;

   // input stage
   req_word_type in_word_ff;
   req_word_type in_word_in;
   logic         in_valid_ff;
   logic         in_valid_in;

   // response stage
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;

   rsp_word_type decoded;
   logic         advance;

   // ---- csr ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   // only the first register exists; other addresses are ignored
   assign little_endian_in = (csr_write && csr_paddr == CSR_ADDR_LITTLE_ENDIAN) ?
                             csr_pwdata[0] : little_endian_ff;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_ADDR_LITTLE_ENDIAN) begin
         csr_prdata[0] = little_endian_ff;
      end
   end

   // ---- pipeline control ----
   // both stages move when the response slot is empty or being taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign in_word_in   = (req_ready && req_valid) ? req_data : in_word_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   assign rsp_word_in  = (advance && in_valid_ff) ? decoded : rsp_word_ff;

   // ---- decode between the two registers ----
   mbp_decode u_decode (
      .little_endian (little_endian_ff),
      .req_word      (in_word_ff),
      .rsp_word      (decoded)
   );

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         little_endian_ff <= 1'b0;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         little_endian_ff <= little_endian_in;
         in_valid_ff      <= in_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

[rtl/mbp_decode.sv]
// ----------------------------------------------------------------------------
// mbp_decode
// byte order, instruction class and branch target for one word
// ----------------------------------------------------------------------------
module mbp_decode
   import mbp_pkg::*;
(
   input  logic         little_endian,
   input  req_word_type req_word,
   output rsp_word_type rsp_word
);

   // major opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_COP1X   = 6'h13;
   localparam logic [5:0] OP_BEQL    = 6'h14;
   localparam logic [5:0] OP_BNEL    = 6'h15;
   localparam logic [5:0] OP_BLEZL   = 6'h16;
   localparam logic [5:0] OP_BGTZL   = 6'h17;
   localparam logic [5:0] OP_LDL     = 6'h1a;
   localparam logic [5:0] OP_LDR     = 6'h1b;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LWL     = 6'h22;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_LWR     = 6'h26;
   localparam logic [5:0] OP_LWU     = 6'h27;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SWL     = 6'h2a;
   localparam logic [5:0] OP_SW      = 6'h2b;
   localparam logic [5:0] OP_SDL     = 6'h2c;
   localparam logic [5:0] OP_SDR     = 6'h2d;
   localparam logic [5:0] OP_SWR     = 6'h2e;
   localparam logic [5:0] OP_LL      = 6'h30;
   localparam logic [5:0] OP_LWC1    = 6'h31;
   localparam logic [5:0] OP_LWC2    = 6'h32;
   localparam logic [5:0] OP_LLD     = 6'h34;
   localparam logic [5:0] OP_LDC1    = 6'h35;
   localparam logic [5:0] OP_LDC2    = 6'h36;
   localparam logic [5:0] OP_LD      = 6'h37;
   localparam logic [5:0] OP_SC      = 6'h38;
   localparam logic [5:0] OP_SWC1    = 6'h39;
   localparam logic [5:0] OP_SWC2    = 6'h3a;
   localparam logic [5:0] OP_SCD     = 6'h3c;
   localparam logic [5:0] OP_SDC1    = 6'h3d;
   localparam logic [5:0] OP_SDC2    = 6'h3e;
   localparam logic [5:0] OP_SD      = 6'h3f;

   // special funct codes
   localparam logic [5:0] FN_JR      = 6'h08;
   localparam logic [5:0] FN_JALR    = 6'h09;
   localparam logic [5:0] FN_SYSCALL = 6'h0c;
   localparam logic [5:0] FN_BREAK   = 6'h0d;
   localparam logic [5:0] FN_TGE     = 6'h30;
   localparam logic [5:0] FN_TGEU    = 6'h31;
   localparam logic [5:0] FN_TLT     = 6'h32;
   localparam logic [5:0] FN_TLTU    = 6'h33;
   localparam logic [5:0] FN_TEQ     = 6'h34;
   localparam logic [5:0] FN_TNE     = 6'h36;

   // cop1x funct codes
   localparam logic [5:0] FN_LWXC1   = 6'h00;
   localparam logic [5:0] FN_LDXC1   = 6'h01;
   localparam logic [5:0] FN_SWXC1   = 6'h08;
   localparam logic [5:0] FN_SDXC1   = 6'h09;

   // regimm rt codes
   localparam logic [4:0] RT_BLTZ    = 5'h00;
   localparam logic [4:0] RT_BGEZ    = 5'h01;
   localparam logic [4:0] RT_BLTZL   = 5'h02;
   localparam logic [4:0] RT_BGEZL   = 5'h03;
   localparam logic [4:0] RT_BLTZAL  = 5'h10;
   localparam logic [4:0] RT_BGEZAL  = 5'h11;
   localparam logic [4:0] RT_BLTZALL = 5'h12;
   localparam logic [4:0] RT_BGEZALL = 5'h13;

   localparam logic [4:0] REG_RA     = 5'd31;

   logic [31:0]    word;
   logic [5:0]     op;
   logic [4:0]     rs;
   logic [4:0]     rt;
   logic [5:0]     fn;
   insn_class_type cls;
   logic           rel_hit;
   logic           region_hit;
   logic [18:0]    rel_offset;
   logic [63:0]    rel_target;
   logic [63:0]    pc_plus4;
   logic [63:0]    region_target;

   // big-endian puts byte 0 at the top of the word
   assign word = little_endian ? req_word.instruction_bytes :
                 {req_word.instruction_bytes[7:0],   req_word.instruction_bytes[15:8],
                  req_word.instruction_bytes[23:16], req_word.instruction_bytes[31:24]};

   assign op = word[31:26];
   assign rs = word[25:21];
   assign rt = word[20:16];
   assign fn = word[5:0];

   always_comb begin
      cls        = CLASS_OTHER;
      rel_hit    = 1'b0;
      region_hit = 1'b0;
      unique case (op)
         OP_SPECIAL: begin
            unique case (fn)
               FN_JR:   cls = (rs == REG_RA) ? CLASS_RETURN : CLASS_UNC_IND;
               FN_JALR: cls = CLASS_CALL_IND;
               FN_SYSCALL, FN_BREAK, FN_TGE, FN_TGEU, FN_TLT, FN_TLTU, FN_TEQ, FN_TNE:
                  cls = CLASS_SYSTRAP;
               default: cls = CLASS_OTHER;
            endcase
         end
         OP_REGIMM: begin
            unique case (rt)
               RT_BLTZ, RT_BGEZ, RT_BLTZL, RT_BGEZL: begin
                  cls     = CLASS_COND;
                  rel_hit = 1'b1;
               end
               RT_BLTZAL, RT_BGEZAL, RT_BLTZALL, RT_BGEZALL: begin
                  cls     = CLASS_CALL;
                  rel_hit = 1'b1;
               end
               // trap-immediate forms and the rest
               default: cls = CLASS_OTHER;
            endcase
         end
         OP_COP1X: begin
            unique case (fn)
               FN_LWXC1, FN_LDXC1: cls = CLASS_LOAD;
               FN_SWXC1, FN_SDXC1: cls = CLASS_STORE;
               default:            cls = CLASS_OTHER;
            endcase
         end
         OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR, OP_LWU, OP_LL, OP_LWC1,
         OP_LWC2, OP_LD, OP_LDL, OP_LDR, OP_LLD, OP_LDC1, OP_LDC2:
            cls = CLASS_LOAD;
         OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR, OP_SC, OP_SWC1, OP_SWC2, OP_SD, OP_SDL,
         OP_SDR, OP_SCD, OP_SDC1, OP_SDC2:
            cls = CLASS_STORE;
         OP_J: begin
            cls        = CLASS_UNC_DIR;
            region_hit = 1'b1;
         end
         OP_JAL: begin
            cls        = CLASS_CALL;
            region_hit = 1'b1;
         end
         // beq with the same register on both sides always goes
         OP_BEQ: begin
            cls     = (rs == rt) ? CLASS_UNC_DIR : CLASS_COND;
            rel_hit = 1'b1;
         end
         OP_BNE, OP_BLEZ, OP_BGTZ, OP_BEQL, OP_BNEL, OP_BLEZL, OP_BGTZL: begin
            cls     = CLASS_COND;
            rel_hit = 1'b1;
         end
         default: cls = CLASS_OTHER;
      endcase
   end

   // offset*4 + 4 folded into one narrow add, then one wide add with the pc
   assign rel_offset    = {word[15], word[15:0], 2'b00} + 19'd4;
   assign rel_target    = req_word.program_counter + {{45{rel_offset[18]}}, rel_offset};
   assign pc_plus4      = req_word.program_counter + 64'd4;
   assign region_target = {pc_plus4[63:28], word[25:0], 2'b00};

   always_comb begin
      rsp_word.insn_class     = cls;
      rsp_word.target_valid   = rel_hit | region_hit;
      rsp_word.target_address = region_hit ? region_target :
                                rel_hit    ? rel_target    : 64'd0;
      rsp_word.delay_slots    = (cls >= CLASS_COND) && (cls <= CLASS_RETURN);
   end

endmodule
